[rtl/core/jur_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jur_pkg
// Shared types and constants of the unstuffing bit reader.
// ----------------------------------------------------------------------------
package jur_pkg;

    localparam logic [7:0] MARKER_BYTE   = 8'hFF;
    localparam logic [7:0] STUFF_BYTE    = 8'h00;
    localparam logic [4:0] RST_PREFIX    = 5'b11010;
    localparam int         BYTE_W        = 8;
    localparam int         BIT_CNT_W     = 3;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT_IDX = 3'd7;

    localparam int         Q_DEPTH       = 2;
    localparam int         Q_PTR_W       = 1;
    localparam int         Q_CNT_W       = 2;

    typedef struct packed {
        logic              is_err;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

endpackage : jur_pkg
`default_nettype wire

[rtl/core/jur_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jur_front
// Accepts raw segment bytes, tracks the pending marker and queues work.
// ----------------------------------------------------------------------------
module jur_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_stream_end,
    output logic                   o_stall,
    input  wire jur_pkg::t_q_status i_q_status,
    output logic                   o_push,
    output jur_pkg::t_cmd          o_cmd,
    output logic                   o_pending
);
    import jur_pkg::*;

    logic r_pending;
    logic n_pending;
    logic accept;
    logic is_ff;
    logic is_zero;
    logic is_rst;
    logic want_push;
    t_cmd cmd;

    assign o_stall   = i_q_status.full;
    assign accept    = i_valid && !i_q_status.full;
    assign is_ff     = (i_data_byte == MARKER_BYTE);
    assign is_zero   = (i_data_byte == STUFF_BYTE);
    assign is_rst    = (i_data_byte[7:3] == RST_PREFIX);

    always_comb begin
        n_pending  = r_pending;
        want_push  = 1'b0;
        cmd.is_err = 1'b0;
        cmd.data   = i_data_byte;
        priority if (!r_pending) begin
            if (is_ff) begin
                if (i_stream_end) begin
                    want_push  = 1'b1;
                    cmd.is_err = 1'b1;
                end else begin
                    n_pending = 1'b1;
                end
            end else begin
                want_push = 1'b1;
            end
        end else if (is_ff) begin
            if (i_stream_end) begin
                n_pending  = 1'b0;
                want_push  = 1'b1;
                cmd.is_err = 1'b1;
            end
        end else begin
            n_pending = 1'b0;
            priority if (is_zero) begin
                want_push = 1'b1;
                cmd.data  = MARKER_BYTE;
            end else if (is_rst) begin
                want_push = 1'b0;
            end else begin
                want_push  = 1'b1;
                cmd.is_err = 1'b1;
            end
        end
    end

    assign o_push    = accept && want_push;
    assign o_cmd     = cmd;
    assign o_pending = r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (accept) begin
            r_pending <= n_pending;
        end
    end

endmodule : jur_front
`default_nettype wire

[rtl/core/jur_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jur_queue
// Short command queue between the classifier and the bit serializer.
// ----------------------------------------------------------------------------
module jur_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire jur_pkg::t_cmd      i_cmd,
    input  wire logic               i_pop,
    output jur_pkg::t_cmd           o_cmd,
    output jur_pkg::t_q_status      o_status
);
    import jur_pkg::*;

    t_cmd                 r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_status.full      = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.not_empty = (r_count != '0);
    assign do_push            = i_push && !o_status.full;
    assign do_pop             = i_pop && o_status.not_empty;
    assign o_cmd              = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule : jur_queue
`default_nettype wire

[rtl/core/jur_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jur_back
// Serializes queued bytes MSB first and emits error transactions.
// ----------------------------------------------------------------------------
module jur_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire jur_pkg::t_cmd      i_cmd,
    input  wire jur_pkg::t_q_status i_q_status,
    output logic                    o_pop,
    output logic                    o_valid,
    output logic                    o_bit_value,
    output logic                    o_last_bit,
    output logic                    o_marker_error,
    input  wire logic               i_stall
);
    import jur_pkg::*;

    logic                  r_busy;
    logic                  n_busy;
    logic [BYTE_W-1:0]     r_shift;
    logic [BYTE_W-1:0]     n_shift;
    logic [BIT_CNT_W-1:0]  r_cnt;
    logic [BIT_CNT_W-1:0]  n_cnt;
    logic                  r_valid;
    logic                  n_valid;
    logic                  r_bit;
    logic                  n_bit;
    logic                  r_last;
    logic                  n_last;
    logic                  r_err;
    logic                  n_err;
    logic                  advance;

    assign advance = !r_valid || !i_stall;

    always_comb begin
        n_busy  = r_busy;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        n_bit   = r_bit;
        n_last  = r_last;
        n_err   = r_err;
        o_pop   = 1'b0;
        if (advance) begin
            priority if (r_busy) begin
                n_valid = 1'b1;
                n_bit   = r_shift[BYTE_W-1];
                n_last  = (r_cnt == LAST_BIT_IDX);
                n_err   = 1'b0;
                n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                n_cnt   = r_cnt + 1'b1;
                n_busy  = (r_cnt != LAST_BIT_IDX);
            end else if (i_q_status.not_empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                if (i_cmd.is_err) begin
                    n_bit  = 1'b0;
                    n_last = 1'b0;
                    n_err  = 1'b1;
                end else begin
                    n_bit   = i_cmd.data[BYTE_W-1];
                    n_last  = 1'b0;
                    n_err   = 1'b0;
                    n_shift = {i_cmd.data[BYTE_W-2:0], 1'b0};
                    n_cnt   = BIT_CNT_W'(1);
                    n_busy  = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bit   <= n_bit;
        r_last  <= n_last;
        r_err   <= n_err;
    end

    assign o_valid        = r_valid;
    assign o_bit_value    = r_bit;
    assign o_last_bit     = r_last;
    assign o_marker_error = r_err;

endmodule : jur_back
`default_nettype wire

[rtl/core/jpeg_unstuffing_bit_reader_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jpeg_unstuffing_bit_reader_core
// Unstuffs JPEG entropy-coded bytes and emits their data bits MSB first.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+----------------------------------------
//   in      | i_valid | o_stall | i_data_byte, i_stream_end
//   out     | o_valid | i_stall | o_bit_value, o_last_bit, o_marker_error
//
// A data byte yields eight output transactions, one per cycle while i_stall is
// low, from the serializer shift register; the queue takes further bytes meanwhile.
// An error yields a single output transaction; fill and restart bytes yield none.
// Input stalls only when the two-entry command queue is full.
// Synchronous active-low reset clears the marker state, queue and output.
// ----------------------------------------------------------------------------
module jpeg_unstuffing_bit_reader_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_stream_end,
    output logic             o_stall,
    output logic             o_valid,
    output logic             o_bit_value,
    output logic             o_last_bit,
    output logic             o_marker_error,
    input  wire logic        i_stall
);
    import jur_pkg::*;

    logic      push;
    logic      pop;
    logic      pending;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;

    jur_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .o_stall      (o_stall),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_pending    (pending)
    );

    jur_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    jur_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_bit_value    (o_bit_value),
        .o_last_bit     (o_last_bit),
        .o_marker_error (o_marker_error),
        .i_stall        (i_stall)
    );

`ifndef SYNTHESIS
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_marker_error) |-> (!o_bit_value && !o_last_bit))
        else $error("error transaction carries data bits");

    a_fill_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && pending && (i_data_byte == MARKER_BYTE)
         && !i_stream_end) |-> !push)
        else $error("fill byte queued work");

    a_resolve_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && pending && push) |=> !pending)
        else $error("marker still pending after resolving byte");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_status.not_empty)
        else $error("pop from empty queue");
`endif

endmodule : jpeg_unstuffing_bit_reader_core
`default_nettype wire

[test/jpeg_unstuffing_bit_reader_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_unstuffing_bit_reader_core_tb
// Self-checking bench for the JPEG byte unstuffing bit reader. Raw segment
// bytes go in over a valid/stall channel and the bench predicts every output
// bit, last-bit flag and marker error with its own copy of the marker state.
// It runs directed marker cases, then random segments with data, stuffed,
// restart, invalid and truncated pieces, a back-to-back run and random noise.
// Random idling and stalls are applied on both sides but in the back-to-back run.
// ----------------------------------------------------------------------------
module jpeg_unstuffing_bit_reader_core_tb;
    import jur_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int IDLE_PERCENT  = 15;

    typedef enum int {
        PIECE_DATA,
        PIECE_STUFFED,
        PIECE_RESTART,
        PIECE_INVALID,
        PIECE_TRUNCATED
    } t_piece_kind;

    typedef struct packed {
        logic bit_value;
        logic last_bit;
        logic marker_error;
    } t_bit_result;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic [7:0] i_data_byte    = 8'h00;
    logic       i_stream_end   = 1'b0;
    logic       i_stall        = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_bit_value;
    logic       o_last_bit;
    logic       o_marker_error;

    t_bit_result expected_bits[$];
    logic        pending_marker = 1'b0;
    bit          tx_idle_en     = 1'b1;
    bit          rx_idle_en     = 1'b1;
    int          cycle_count    = 0;
    int          fail_count     = 0;
    int          mismatch_count = 0;
    int          bytes_sent     = 0;
    int          bits_checked   = 0;
    int          errors_checked = 0;

    jpeg_unstuffing_bit_reader_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_data_byte    (i_data_byte),
        .i_stream_end   (i_stream_end),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_bit_value    (o_bit_value),
        .o_last_bit     (o_last_bit),
        .o_marker_error (o_marker_error),
        .i_stall        (i_stall)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (rx_idle_en)
            i_stall = ($urandom_range(0, 99) < IDLE_PERCENT);
        else
            i_stall = 1'b0;
    end

    function automatic void push_byte_bits(input logic [7:0] value);
        t_bit_result r;
        for (int k = 0; k < BYTE_W; k++) begin
            r.bit_value    = value[BYTE_W-1-k];
            r.last_bit     = (k == BYTE_W - 1);
            r.marker_error = 1'b0;
            expected_bits.push_back(r);
        end
    endfunction

    function automatic void push_marker_error();
        t_bit_result r;
        r = '{bit_value: 1'b0, last_bit: 1'b0, marker_error: 1'b1};
        expected_bits.push_back(r);
    endfunction

    function automatic void unstuff_predict(input logic [7:0] b, input logic eos);
        if (!pending_marker) begin
            if (b == MARKER_BYTE) begin
                if (eos)
                    push_marker_error();
                else
                    pending_marker = 1'b1;
            end else begin
                push_byte_bits(b);
            end
        end else if (b == MARKER_BYTE) begin
            if (eos) begin
                pending_marker = 1'b0;
                push_marker_error();
            end
        end else begin
            pending_marker = 1'b0;
            if (b == STUFF_BYTE)
                push_byte_bits(MARKER_BYTE);
            else if (b[7:3] != RST_PREFIX)
                push_marker_error();
        end
    endfunction

    function automatic void check_bit_result();
        t_bit_result want;
        if (expected_bits.size() == 0) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected transaction: bit %0b last %0b err %0b",
                         o_bit_value, o_last_bit, o_marker_error);
            return;
        end
        want = expected_bits.pop_front();
        bits_checked++;
        if (want.marker_error)
            errors_checked++;
        if (o_bit_value !== want.bit_value || o_last_bit !== want.last_bit ||
            o_marker_error !== want.marker_error) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch: expected bit %0b last %0b err %0b, got %0b %0b %0b",
                         want.bit_value, want.last_bit, want.marker_error,
                         o_bit_value, o_last_bit, o_marker_error);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                unstuff_predict(i_data_byte, i_stream_end);
            if (o_valid && !i_stall)
                check_bit_result();
        end
    end

    // enter and leave on a falling edge; valid stays high for back-to-back bytes
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (tx_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_data_byte  = b;
        i_stream_end = eos;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid = 1'b0;
        while (expected_bits.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_data_byte();
        return 8'($urandom_range(0, 254));
    endfunction

    function automatic logic [7:0] rand_invalid_marker();
        logic [7:0] b;
        b = 8'($urandom_range(1, 254));
        while (b[7:3] == RST_PREFIX)
            b = 8'($urandom_range(1, 254));
        return b;
    endfunction

    task automatic send_marker(input int fill, input logic [7:0] second, input logic eos);
        send_byte(MARKER_BYTE, 1'b0);
        repeat (fill) send_byte(MARKER_BYTE, 1'b0);
        send_byte(second, eos);
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_marker(0, STUFF_BYTE, 1'b0);
        send_marker(2, STUFF_BYTE, 1'b0);
        send_marker(1, {RST_PREFIX, 3'd0}, 1'b0);
        send_marker(0, {RST_PREFIX, 3'd7}, 1'b0);
        send_marker(0, 8'hC4, 1'b0);
        send_marker(0, 8'hCF, 1'b0);
        send_marker(0, 8'hD8, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(MARKER_BYTE, 1'b1);
        send_marker(0, MARKER_BYTE, 1'b1);
        send_byte(8'hFE, 1'b1);
        send_marker(0, STUFF_BYTE, 1'b1);
        send_marker(0, {RST_PREFIX, 3'd3}, 1'b1);
        send_byte(8'h5A, 1'b0);
        drain_results();
    endtask

    task automatic send_random_piece(input int noise_pct);
        t_piece_kind kind;
        int          pick;
        logic        eos;
        pick = $urandom_range(0, 99);
        eos  = ($urandom_range(0, 99) < 6);
        if (pick < noise_pct) begin
            send_byte(8'($urandom), ($urandom_range(0, 99) < 10));
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 62)      kind = PIECE_DATA;
        else if (pick < 78) kind = PIECE_STUFFED;
        else if (pick < 88) kind = PIECE_RESTART;
        else if (pick < 96) kind = PIECE_INVALID;
        else                kind = PIECE_TRUNCATED;
        case (kind)
            PIECE_DATA: begin
                send_byte(rand_data_byte(), eos);
            end
            PIECE_STUFFED: begin
                send_marker($urandom_range(0, 2), STUFF_BYTE, eos);
            end
            PIECE_RESTART: begin
                send_marker($urandom_range(0, 2), {RST_PREFIX, 3'($urandom)}, eos);
            end
            PIECE_INVALID: begin
                send_marker($urandom_range(0, 1), rand_invalid_marker(), eos);
            end
            default: begin
                send_marker($urandom_range(0, 2) == 0 ? 0 : 1, MARKER_BYTE, 1'b1);
            end
        endcase
    endtask

    task automatic test_random_segments();
        repeat (45) send_random_piece(0);
        drain_results();
    endtask

    task automatic test_random_noise();
        repeat (30) send_random_piece(100);
        drain_results();
    endtask

    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (25) send_random_piece(10);
        drain_results();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_segments();
        test_back_to_back();
        test_random_noise();

        $display("Run covered %0d input bytes: data, stuffed, restart, invalid and truncated",
                 bytes_sent);
        $display("markers with random gaps and stalls; %0d output bits checked, %0d errors",
                 bits_checked, errors_checked);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule : jpeg_unstuffing_bit_reader_core_tb

[filelist.f]
rtl/core/jur_pkg.sv
rtl/core/jur_front.sv
rtl/core/jur_queue.sv
rtl/core/jur_back.sv
rtl/core/jpeg_unstuffing_bit_reader_core.sv
test/jpeg_unstuffing_bit_reader_core_tb.sv
